### hw/rtl/htfd_pkg.sv
// Shared types and constants for the humidity/temperature frame decoder.
package htfd_pkg;

  localparam int BYTE_W      = 8;
  localparam int CENTI_W     = 15;
  localparam int STATUS_W    = 2;
  localparam int RAW_W       = 16;
  localparam int SPAN_W      = 15;
  localparam int PROD_W      = RAW_W + SPAN_W;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 8;

  typedef logic [BYTE_W-1:0]          byte_t;
  typedef logic signed [CENTI_W-1:0]  centi_t;
  typedef logic [STATUS_W-1:0]        status_t;
  typedef logic [RAW_W-1:0]           raw_t;
  typedef logic [PROD_W-1:0]          prod_t;
  typedef logic [CFG_INDEX_W-1:0]     cfg_index_t;
  typedef logic [CFG_DATA_W-1:0]      cfg_data_t;

  // Position of a byte within the six-byte reply
  typedef enum logic [2:0] {
    POS_T_HI  = 3'd0,
    POS_T_LO  = 3'd1,
    POS_T_CRC = 3'd2,
    POS_H_HI  = 3'd3,
    POS_H_LO  = 3'd4,
    POS_H_CRC = 3'd5
  } pos_t;

  localparam status_t STATUS_OK      = 2'd0;
  localparam status_t STATUS_T_CRC   = 2'd1;
  localparam status_t STATUS_H_CRC   = 2'd2;

  localparam cfg_index_t CFG_CRC_INIT = 1'd0;
  localparam cfg_index_t CFG_CRC_POLY = 1'd1;

  localparam byte_t CRC_INIT_RST = 8'hFF;
  localparam byte_t CRC_POLY_RST = 8'h31;

  localparam logic [SPAN_W-1:0] TEMP_SPAN   = 15'd17500;
  localparam logic [SPAN_W-1:0] HUM_SPAN    = 15'd12500;
  localparam centi_t            TEMP_OFFSET = -15'sd4500;
  localparam centi_t            HUM_OFFSET  = -15'sd600;

endpackage

### hw/rtl/htfd_if.sv
// Valid/ready channel interfaces for reply bytes and decoded results.
interface htfd_in_if;
  import htfd_pkg::*;

  logic  valid;
  logic  ready;
  byte_t rx_byte;
  logic  frame_start;

  modport source (output valid, output rx_byte, output frame_start, input ready);
  modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

interface htfd_out_if;
  import htfd_pkg::*;

  logic    valid;
  logic    ready;
  centi_t  temperature_centi;
  centi_t  humidity_centi;
  status_t status;

  modport source (output valid, output temperature_centi, output humidity_centi,
                  output status, input ready);
  modport sink   (input valid, input temperature_centi, input humidity_centi,
                  input status, output ready);
endinterface

### hw/rtl/humidity_temp_frame_decoder.sv
// A result is presented in the cycle after the H_crc byte is accepted.
// One byte is accepted per cycle unless an untaken result stalls the input; one result per six-byte reply.
// Raw words are scaled by a product taken as each low byte arrives, so the
// last byte needs only adds. Reset clears position, CRC state, held readings
// and the result valid, and restores crc_init to 0xFF and crc_poly to 0x31.
module humidity_temp_frame_decoder (
  input  logic                   clk,
  input  logic                   rst,
  htfd_in_if.sink                rx,
  htfd_out_if.source             res,
  input  logic                   cfg_we,
  input  htfd_pkg::cfg_index_t   cfg_index,
  input  htfd_pkg::cfg_data_t    cfg_data
);
  import htfd_pkg::*;

  // round(span * raw / 65535) + offset; n / 65535 is exact as (n + n>>16 + 1) >> 16
  function automatic centi_t scale(input prod_t prod, input centi_t offset);
    logic [31:0]        n;
    logic [31:0]        s;
    logic [CENTI_W-1:0] q;
    n = {1'b0, prod} + 32'd32767;
    s = n + {16'd0, n[31:16]} + 32'd1;
    q = s[30:16];
    return centi_t'(q + offset);
  endfunction

  byte_t   crc_init;
  byte_t   crc_poly;
  pos_t    pos;
  byte_t   running_crc;
  byte_t   t_hi;
  byte_t   h_hi;
  prod_t   t_prod;
  prod_t   h_prod;
  logic    t_failed;
  centi_t  held_t;
  centi_t  held_h;
  logic    res_valid;
  centi_t  res_t;
  centi_t  res_h;
  status_t res_status;

  logic    rx_fire;
  pos_t    cur_pos;
  byte_t   crc_seed;
  byte_t   crc_upd;
  raw_t    raw_word;
  status_t status_next;
  centi_t  held_t_next;
  centi_t  held_h_next;

  assign rx_fire  = rx.valid && rx.ready;
  assign rx.ready = !res_valid || res.ready;
  assign cur_pos  = rx.frame_start ? POS_T_HI : pos;

  // Each word's CRC starts from crc_init
  assign crc_seed = (cur_pos == POS_T_HI || cur_pos == POS_H_HI) ? crc_init : running_crc;

  htfd_crc8 u_crc (
    .crc_in  (crc_seed),
    .data    (rx.rx_byte),
    .poly    (crc_poly),
    .crc_out (crc_upd)
  );

  assign raw_word = (cur_pos == POS_T_LO) ? {t_hi, rx.rx_byte} : {h_hi, rx.rx_byte};

  always_comb begin
    status_next = STATUS_OK;
    held_t_next = held_t;
    held_h_next = held_h;
    if (t_failed) begin
      status_next = STATUS_T_CRC;
    end else if (running_crc != rx.rx_byte) begin
      status_next = STATUS_H_CRC;
    end else begin
      held_t_next = scale(t_prod, TEMP_OFFSET);
      held_h_next = scale(h_prod, HUM_OFFSET);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_init <= CRC_INIT_RST;
      crc_poly <= CRC_POLY_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CRC_INIT: crc_init <= cfg_data;
        CFG_CRC_POLY: crc_poly <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos         <= POS_T_HI;
      running_crc <= '0;
      t_hi        <= '0;
      h_hi        <= '0;
      t_failed    <= 1'b0;
      held_t      <= '0;
      held_h      <= '0;
    end else if (rx_fire) begin
      case (cur_pos)
        POS_T_HI: begin
          running_crc <= crc_upd;
          t_hi        <= rx.rx_byte;
          pos         <= POS_T_LO;
        end
        POS_T_LO: begin
          running_crc <= crc_upd;
          pos         <= POS_T_CRC;
        end
        POS_T_CRC: begin
          t_failed <= (running_crc != rx.rx_byte);
          pos      <= POS_H_HI;
        end
        POS_H_HI: begin
          running_crc <= crc_upd;
          h_hi        <= rx.rx_byte;
          pos         <= POS_H_LO;
        end
        POS_H_LO: begin
          running_crc <= crc_upd;
          pos         <= POS_H_CRC;
        end
        default: begin
          held_t <= held_t_next;
          held_h <= held_h_next;
          pos    <= POS_T_HI;
        end
      endcase
    end
  end

  // Take the scaling product as each low byte arrives
  always_ff @(posedge clk) begin
    if (rx_fire && cur_pos == POS_T_LO) begin
      t_prod <= prod_t'(raw_word) * prod_t'(TEMP_SPAN);
    end
    if (rx_fire && cur_pos == POS_H_LO) begin
      h_prod <= prod_t'(raw_word) * prod_t'(HUM_SPAN);
    end
  end

  // Hold the result until taken; a final byte loads a new one
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      res_valid <= (rx_fire && cur_pos == POS_H_CRC) || (res_valid && !res.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (rx_fire && cur_pos == POS_H_CRC) begin
      res_t      <= held_t_next;
      res_h      <= held_h_next;
      res_status <= status_next;
    end
  end

  assign res.valid             = res_valid;
  assign res.temperature_centi = res_t;
  assign res.humidity_centi    = res_h;
  assign res.status            = res_status;

  a_result_from_last_byte: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(rx_fire && cur_pos == POS_H_CRC))
    else $error("result raised without a final reply byte");

  a_bad_crc_holds: assert property (@(posedge clk) disable iff (rst)
    (rx_fire && cur_pos == POS_H_CRC && status_next != STATUS_OK)
      |=> (held_t == $past(held_t) && held_h == $past(held_h)))
    else $error("held readings changed on a failed CRC");

  a_no_spurious_result: assert property (@(posedge clk) disable iff (rst)
    (rx_fire && cur_pos != POS_H_CRC && res.ready) |=> !res_valid)
    else $error("result produced for a mid-frame item");

endmodule

### hw/rtl/htfd_crc8.sv
// MSB-first CRC-8 update over one byte, unrolled over its eight bits.
module htfd_crc8 (
  input  htfd_pkg::byte_t crc_in,
  input  htfd_pkg::byte_t data,
  input  htfd_pkg::byte_t poly,
  output htfd_pkg::byte_t crc_out
);
  import htfd_pkg::*;

  always_comb begin
    byte_t c;
    c = crc_in ^ data;
    for (int k = 0; k < BYTE_W; k++) begin
      if (c[BYTE_W-1]) begin
        c = {c[BYTE_W-2:0], 1'b0} ^ poly;
      end else begin
        c = {c[BYTE_W-2:0], 1'b0};
      end
    end
    crc_out = c;
  end

endmodule
